// ----- hdl/hng_pkg.sv -----
// ----------------------------------------------------------------------------
// hng_pkg
// Shared types and constants of the heightmap normal generator.
// ----------------------------------------------------------------------------
package hng_pkg;

  localparam int HEIGHT_W     = 16;
  localparam int GRID_W       = 9;
  localparam int COORD_W      = 8;
  localparam int NORM_W       = 16;
  localparam int NORM_Y_W     = 15;
  localparam int DIFF_W       = 17;
  localparam int MAG_W        = 16;
  localparam int SQ_W         = 32;
  localparam int SUM_W        = 34;
  localparam int QUO_W        = 31;
  localparam int MAX_SIZE_DEF = 256;
  localparam int GRID_RESET   = 256;
  // square of the fixed vertical component (512 * 512)
  localparam logic [SQ_W-1:0] UNIT_SQ = 32'd262144;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_OUT
  } ctl_state_e;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_SQA,
    NS_SQC,
    NS_SUM,
    NS_DIV,
    NS_ROOT
  } norm_state_e;

  // finished normal from the arithmetic unit
  typedef struct packed {
    logic                       done;
    logic signed [NORM_W-1:0]   nx;
    logic        [NORM_Y_W-1:0] ny;
    logic signed [NORM_W-1:0]   nz;
  } norm_res_t;

endpackage

// ----- hdl/hng_line_store.sv -----
// ----------------------------------------------------------------------------
// hng_line_store
// Three-row height store, one write and one registered read port.
// ----------------------------------------------------------------------------
module hng_line_store import hng_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(3*MAX_SIZE)-1:0]     waddr_i,
  input  logic [HEIGHT_W-1:0]               wdata_i,
  input  logic [$clog2(3*MAX_SIZE)-1:0]     raddr_i,
  output logic [HEIGHT_W-1:0]               rdata_o
);

  localparam int Depth = 3 * MAX_SIZE;

  logic [HEIGHT_W-1:0] mem [Depth];
  logic [HEIGHT_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/hng_norm_unit.sv -----
// ----------------------------------------------------------------------------
// hng_norm_unit
// Normalizes (a, 512, c): squares, restoring divide and digit-wise square
// root, shared over the three components.
// ----------------------------------------------------------------------------
module hng_norm_unit import hng_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DIFF_W-1:0] a_i,
  input  logic signed [DIFF_W-1:0] c_i,
  output norm_res_t                res_o
);

  norm_state_e state_q, state_d;

  logic [MAG_W-1:0]    am_q, cm_q;
  logic                a_neg_q, c_neg_q;
  logic [SQ_W-1:0]     sqa_q, sqc_q;
  logic [SUM_W-1:0]    s_q;
  logic [1:0]          comp_q;
  logic [4:0]          it_q;
  logic [SUM_W-1:0]    rem_q;
  logic                lsb_q;
  logic [QUO_W-1:0]    quo_q;
  logic [31:0]         v_q, r_q, bit_q;
  logic [NORM_Y_W-1:0] mx_q, my_q, mz_q;
  logic                done_q;

  logic [SUM_W:0]      trial;
  logic [SUM_W:0]      trial_sub;
  logic [31:0]         rb;
  logic [NORM_Y_W-1:0] rounded;

  assign trial     = {rem_q, lsb_q};
  assign trial_sub = trial - {1'b0, s_q};
  assign rb        = r_q + bit_q;
  assign rounded   = NORM_Y_W'((17'(r_q[15:0]) + 17'd1) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == NS_ROOT) && (bit_q == 32'd0) && (comp_q == 2'd2);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      NS_IDLE: if (start_i) state_d = NS_SQA;
      NS_SQA:  state_d = NS_SQC;
      NS_SQC:  state_d = NS_SUM;
      NS_SUM:  state_d = NS_DIV;
      NS_DIV:  if (it_q == 5'd0) state_d = NS_ROOT;
      NS_ROOT: begin
        if (bit_q == 32'd0) begin
          state_d = (comp_q == 2'd2) ? NS_IDLE : NS_DIV;
        end
      end
      default: state_d = NS_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      NS_IDLE: begin
        if (start_i) begin
          a_neg_q <= a_i[DIFF_W-1];
          c_neg_q <= c_i[DIFF_W-1];
          am_q    <= MAG_W'(a_i[DIFF_W-1] ? -a_i : a_i);
          cm_q    <= MAG_W'(c_i[DIFF_W-1] ? -c_i : c_i);
        end
      end
      NS_SQA: sqa_q <= am_q * am_q;
      NS_SQC: sqc_q <= cm_q * cm_q;
      NS_SUM: begin
        s_q    <= SUM_W'(sqa_q) + SUM_W'(sqc_q) + SUM_W'(UNIT_SQ);
        comp_q <= 2'd0;
        rem_q  <= SUM_W'(sqa_q >> 1);
        lsb_q  <= sqa_q[0];
        it_q   <= 5'(QUO_W - 1);
        quo_q  <= '0;
      end
      NS_DIV: begin
        // one quotient bit per cycle
        if (!trial_sub[SUM_W]) begin
          rem_q <= SUM_W'(trial_sub);
          quo_q <= {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_q <= SUM_W'(trial);
          quo_q <= {quo_q[QUO_W-2:0], 1'b0};
        end
        lsb_q <= 1'b0;
        it_q  <= it_q - 5'd1;
        if (it_q == 5'd0) begin
          v_q   <= 32'(trial_sub[SUM_W] ? {quo_q[QUO_W-2:0], 1'b0}
                                        : {quo_q[QUO_W-2:0], 1'b1});
          r_q   <= '0;
          bit_q <= 32'h4000_0000;
        end
      end
      NS_ROOT: begin
        // one root digit per cycle
        if (bit_q != 32'd0) begin
          if (v_q >= rb) begin
            v_q <= v_q - rb;
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          case (comp_q)
            2'd0:    mx_q <= rounded;
            2'd1:    my_q <= rounded;
            default: mz_q <= rounded;
          endcase
          comp_q <= comp_q + 2'd1;
          it_q   <= 5'(QUO_W - 1);
          quo_q  <= '0;
          if (comp_q == 2'd0) begin
            rem_q <= SUM_W'(UNIT_SQ >> 1);
            lsb_q <= 1'b0;
          end else begin
            rem_q <= SUM_W'(sqc_q >> 1);
            lsb_q <= sqc_q[0];
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.done = done_q;
  assign res_o.nx   = a_neg_q ? -$signed({1'b0, mx_q}) : $signed({1'b0, mx_q});
  assign res_o.ny   = my_q;
  assign res_o.nz   = c_neg_q ? -$signed({1'b0, mz_q}) : $signed({1'b0, mz_q});

endmodule

// ----- hdl/heightmap_normal_generator.sv -----
// Heightmap normal generator. Heights arrive in raster order for a square
// grid of grid_size vertices per side and are kept in a three-row store.
// Each sample gives up to three normals (the vertex one row above, and on
// the last row the vertex to the left and the final vertex), each marked
// with its coordinates and run_last on the last one. A sample is taken
// only in idle, so the next one waits until every normal of the last
// is out; every normal needs four store reads plus a pass of the shared
// divide and square-root unit. A grid_size write restarts the raster at
// the first vertex; the input is held off while a write is offered.
// ----------------------------------------------------------------------------
// heightmap_normal_generator
// Top level: raster counters, line store sequencing and result port.
// ----------------------------------------------------------------------------
module heightmap_normal_generator import hng_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [GRID_W-1:0]          cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [HEIGHT_W-1:0] height_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [COORD_W-1:0]         vertex_x_o,
  output logic [COORD_W-1:0]         vertex_y_o,
  output logic signed [NORM_W-1:0]   normal_x_o,
  output logic [NORM_Y_W-1:0]        normal_y_o,
  output logic signed [NORM_W-1:0]   normal_z_o,
  output logic                       run_last_o
);

  localparam int CW = $clog2(MAX_SIZE);
  localparam int NW = $clog2(MAX_SIZE + 1);
  localparam int AW = $clog2(3 * MAX_SIZE);

  ctl_state_e state_q, state_d;

  logic [GRID_W-1:0] grid_q;
  logic [CW-1:0]     col_q, row_q, bx_q, by_q;
  logic [1:0]        slot_q, bs_q;
  logic [2:0]        pend_q;
  logic [2:0]        rd_cnt_q;
  logic [HEIGHT_W-1:0] hl_q, hr_q, hu_q, hd_q;
  logic              start_q;
  logic signed [NORM_W-1:0]   nx_q, nz_q;
  logic [NORM_Y_W-1:0]        ny_q;

  logic [NW-1:0]     n_eff;
  logic              in_acc, out_acc;
  logic [CW-1:0]     vx, vy;
  logic [1:0]        vs;
  logic [2:0]        cur;
  logic [CW-1:0]     rx;
  logic [1:0]        rs;
  logic [AW-1:0]     waddr, raddr;
  logic [HEIGHT_W-1:0] rdata;
  logic              last_row;
  logic [2:0]        new_pend;
  logic signed [DIFF_W-1:0] diff_a, diff_c;
  norm_res_t         norm_res;

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  // effective grid size
  always_comb begin
    if (grid_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(grid_q) > 32'(MAX_SIZE)) begin
      n_eff = NW'(MAX_SIZE);
    end else begin
      n_eff = NW'(grid_q);
    end
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign last_row = (32'(row_q) + 1 == 32'(n_eff));
  assign new_pend = {last_row && (32'(col_q) + 1 == 32'(n_eff)),
                     last_row && (col_q != '0),
                     row_q != '0};

  // vertex of the lowest pending result
  always_comb begin
    cur = pend_q & (~pend_q + 3'd1);
    vx  = bx_q;
    vy  = by_q;
    vs  = bs_q;
    if (cur[0]) begin
      vy = by_q - CW'(1);
      vs = slot_dec(bs_q);
    end else if (cur[1]) begin
      vx = bx_q - CW'(1);
    end
  end

  // neighbor read address, falling back to the vertex itself at the border
  always_comb begin
    rx = vx;
    rs = vs;
    case (rd_cnt_q)
      3'd0: if (vx != '0) rx = vx - CW'(1);
      3'd1: if (32'(vx) + 1 < 32'(n_eff)) rx = vx + CW'(1);
      3'd2: if (vy != '0) rs = slot_dec(vs);
      3'd3: if (32'(vy) + 1 < 32'(n_eff)) rs = slot_inc(vs);
      default: ;
    endcase
  end

  assign waddr = AW'(32'(slot_q) * MAX_SIZE + 32'(col_q));
  assign raddr = AW'(32'(rs) * MAX_SIZE + 32'(rx));

  hng_line_store #(
    .MAX_SIZE(MAX_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (waddr),
    .wdata_i (height_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign diff_a = DIFF_W'($signed(hl_q)) - DIFF_W'($signed(hr_q));
  assign diff_c = DIFF_W'($signed(hd_q)) - DIFF_W'($signed(hu_q));

  hng_norm_unit u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .a_i     (diff_a),
    .c_i     (diff_c),
    .res_o   (norm_res)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      grid_q   <= GRID_W'(GRID_RESET);
      col_q    <= '0;
      row_q    <= '0;
      slot_q   <= '0;
      pend_q   <= '0;
      rd_cnt_q <= '0;
      start_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= (state_q == ST_READ) && (rd_cnt_q == 3'd4);
      if (cfg_valid_i && cfg_ready_o) begin
        grid_q <= cfg_data_i;
        col_q  <= '0;
        row_q  <= '0;
        slot_q <= '0;
      end else if (in_acc) begin
        pend_q   <= new_pend;
        rd_cnt_q <= '0;
        if (32'(col_q) + 1 >= 32'(n_eff)) begin
          col_q <= '0;
          if (last_row) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_q + CW'(1);
            slot_q <= slot_inc(slot_q);
          end
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (state_q == ST_READ && rd_cnt_q != 3'd4) begin
        rd_cnt_q <= rd_cnt_q + 3'd1;
      end
      if (out_acc) begin
        pend_q   <= pend_q & ~cur;
        rd_cnt_q <= '0;
      end
    end
  end

  // base position and captured heights
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bx_q <= col_q;
      by_q <= row_q;
      bs_q <= slot_q;
    end
    if (state_q == ST_READ) begin
      case (rd_cnt_q)
        3'd1:    hl_q <= rdata;
        3'd2:    hr_q <= rdata;
        3'd3:    hu_q <= rdata;
        3'd4:    hd_q <= rdata;
        default: ;
      endcase
    end
    if (norm_res.done) begin
      nx_q <= norm_res.nx;
      ny_q <= norm_res.ny;
      nz_q <= norm_res.nz;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc && new_pend != '0) state_d = ST_READ;
      ST_READ: if (rd_cnt_q == 3'd4) state_d = ST_CALC;
      ST_CALC: if (norm_res.done) state_d = ST_OUT;
      ST_OUT: begin
        if (out_acc) begin
          state_d = ((pend_q & ~cur) != '0) ? ST_READ : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cfg_ready_o = (state_q == ST_IDLE);
  // an offered size write takes precedence over a height beat
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign out_valid_o = (state_q == ST_OUT);
  assign vertex_x_o  = COORD_W'(vx);
  assign vertex_y_o  = COORD_W'(vy);
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;
  assign normal_z_o  = nz_q;
  assign run_last_o  = ((pend_q & ~cur) == '0);

  // a pending result beat keeps the input side closed
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result is pending");

  // a stalled result is not dropped
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(vertex_x_o)))
    else $error("stalled result lost");

  // the arithmetic unit only finishes while a normal is awaited
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_res.done |-> (state_q == ST_CALC))
    else $error("normal finished outside calculation");

  // results are only produced for a pending vertex
  a_pend_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (pend_q != '0))
    else $error("busy with no pending vertex");

endmodule
